[rtl/pcsm_pkg.sv]
// Package: opcodes, sub-operations, error codes and field widths of the p-code executor.
package pcsm_pkg;

    localparam int OP_W    = 4;
    localparam int LEV_W   = 2;
    localparam int ARG_W   = 11;
    localparam int ADDR_W  = 11;
    localparam int OUT_W   = 32;
    localparam int IDX_W   = 9;
    localparam int ERR_W   = 2;

    localparam logic [OP_W-1:0] OP_LIT = 4'd0;
    localparam logic [OP_W-1:0] OP_OPR = 4'd1;
    localparam logic [OP_W-1:0] OP_LOD = 4'd2;
    localparam logic [OP_W-1:0] OP_STO = 4'd3;
    localparam logic [OP_W-1:0] OP_CAL = 4'd4;
    localparam logic [OP_W-1:0] OP_INT = 4'd5;
    localparam logic [OP_W-1:0] OP_JMP = 4'd6;
    localparam logic [OP_W-1:0] OP_JPC = 4'd7;
    localparam logic [OP_W-1:0] OP_END = 4'd8;

    localparam logic [3:0] SUB_RET = 4'd0;
    localparam logic [3:0] SUB_NEG = 4'd1;
    localparam logic [3:0] SUB_ADD = 4'd2;
    localparam logic [3:0] SUB_SUB = 4'd3;
    localparam logic [3:0] SUB_MUL = 4'd4;
    localparam logic [3:0] SUB_DIV = 4'd5;
    localparam logic [3:0] SUB_ODD = 4'd6;
    localparam logic [3:0] SUB_EQ  = 4'd7;
    localparam logic [3:0] SUB_NE  = 4'd8;
    localparam logic [3:0] SUB_LT  = 4'd9;
    localparam logic [3:0] SUB_LE  = 4'd10;
    localparam logic [3:0] SUB_GT  = 4'd11;
    localparam logic [3:0] SUB_GE  = 4'd12;

    localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
    localparam logic [ERR_W-1:0] ERR_RANGE = 2'd1;
    localparam logic [ERR_W-1:0] ERR_DIV0  = 2'd2;
    localparam logic [ERR_W-1:0] ERR_BADOP = 2'd3;

endpackage

[rtl/pcsm_div.sv]
// Serial signed divider, truncating toward zero, one quotient bit per cycle.
module pcsm_div #(
    parameter int WORD_BITS = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [WORD_BITS-1:0] dividend,
    input  logic [WORD_BITS-1:0] divisor,
    output logic                 done,
    output logic [WORD_BITS-1:0] quotient
);
    localparam int CNT_W = $clog2(WORD_BITS + 1);

    logic [WORD_BITS-1:0] dq_reg, dq_next;
    logic [WORD_BITS-1:0] den_reg, den_next;
    logic [WORD_BITS:0]   rem_reg, rem_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 neg_reg, neg_next;
    logic                 done_reg, done_next;
    logic [WORD_BITS:0]   rem_sh;

    always_comb begin
        dq_next   = dq_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        neg_next  = neg_reg;
        done_next = 1'b0;
        rem_sh    = {rem_reg[WORD_BITS-1:0], dq_reg[WORD_BITS-1]};
        if (start) begin
            dq_next   = dividend[WORD_BITS-1] ? (~dividend + 1'b1) : dividend;
            den_next  = divisor[WORD_BITS-1] ? (~divisor + 1'b1) : divisor;
            neg_next  = dividend[WORD_BITS-1] ^ divisor[WORD_BITS-1];
            rem_next  = '0;
            cnt_next  = CNT_W'(WORD_BITS);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (rem_sh >= {1'b0, den_reg}) begin
                rem_next = rem_sh - {1'b0, den_reg};
                dq_next  = {dq_reg[WORD_BITS-2:0], 1'b1};
            end else begin
                rem_next = rem_sh;
                dq_next  = {dq_reg[WORD_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        dq_reg  <= dq_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
        neg_reg <= neg_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (~dq_reg + 1'b1) : dq_reg;

endmodule

[rtl/pcode_stack_machine_execute.sv]
// Top level: PL/0 p-code executor over a single-port stack memory.
// Usage:
//  - s_axis word carries one instruction; m_axis word carries one result per instruction.
//  - s_tready is high only while the sequencer is idle; one instruction is in work at a time.
//  - The single memory port takes one read or one write per cycle, and divide
//    runs on the serial divider.
//  - The result sits in an output register; the next instruction is accepted while it waits.
//    If m_tready stays low, the sequencer holds its finished result until the register frees.
//  - After reset the stack memory is swept to zero, one entry per cycle;
//    s_tready stays low for that time. PC resets to 0, base pointer to 1, top pointer to 0.
//  - A fault only advances the PC and reports error_code; divide by zero writes 0 and pops.
module pcode_stack_machine_execute #(
    parameter int STACK_DEPTH = 512,
    parameter int WORD_BITS   = 32,
    parameter int MAX_LEVEL   = 3
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // opcode[3:0], level[5:4], operand[16:6], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata    // next_address[10:0], top_value[42:11], top_index[51:43],
                                   // frame_base[60:52], halted[61], error_code[63:62]
);
    localparam int PW  = $clog2(STACK_DEPTH);
    localparam int CW0 = (WORD_BITS > PW + 2) ? WORD_BITS : PW + 2;
    localparam int CW  = (CW0 > 13) ? CW0 : 13;
    localparam int XW  = (WORD_BITS > 32) ? WORD_BITS : 32;
    localparam int LW  = (MAX_LEVEL > 0) ? $clog2(MAX_LEVEL + 1) : 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);

    localparam logic [4:0] S_CLEAR = 5'd0;
    localparam logic [4:0] S_IDLE  = 5'd1;
    localparam logic [4:0] S_DEC   = 5'd2;
    localparam logic [4:0] S_UNARY = 5'd3;
    localparam logic [4:0] S_BIN1  = 5'd4;
    localparam logic [4:0] S_BIN2  = 5'd5;
    localparam logic [4:0] S_EXEC  = 5'd6;
    localparam logic [4:0] S_DIV   = 5'd7;
    localparam logic [4:0] S_WB    = 5'd8;
    localparam logic [4:0] S_WALK  = 5'd9;
    localparam logic [4:0] S_WALK2 = 5'd10;
    localparam logic [4:0] S_ADDR  = 5'd11;
    localparam logic [4:0] S_LOD2  = 5'd12;
    localparam logic [4:0] S_STO2  = 5'd13;
    localparam logic [4:0] S_CAL2  = 5'd14;
    localparam logic [4:0] S_CAL3  = 5'd15;
    localparam logic [4:0] S_RET1  = 5'd16;
    localparam logic [4:0] S_RET2  = 5'd17;
    localparam logic [4:0] S_JPC2  = 5'd18;
    localparam logic [4:0] S_TOP   = 5'd19;
    localparam logic [4:0] S_OUT   = 5'd20;

    // stack memory
    logic [WORD_BITS-1:0] stack_mem [STACK_DEPTH];
    logic                 mem_we, mem_re;
    logic [PW-1:0]        mem_addr;
    logic [WORD_BITS-1:0] mem_wdata, mem_rdata_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            stack_mem[mem_addr] <= mem_wdata;
        end
        if (mem_re) begin
            mem_rdata_reg <= stack_mem[mem_addr];
        end
    end

    logic [4:0]                 state_reg, state_next;
    logic [PW-1:0]              clr_reg, clr_next;
    logic [pcsm_pkg::ADDR_W-1:0] pc_reg, pc_next;
    logic [PW-1:0]              bp_reg, bp_next, tp_reg, tp_next, link_reg, link_next;
    logic [pcsm_pkg::OP_W-1:0]  op_reg, op_next;
    logic [LW-1:0]              cnt_reg, cnt_next;
    logic [pcsm_pkg::ARG_W-1:0] arg_reg, arg_next;
    logic [WORD_BITS-1:0]       x_reg, x_next, y_reg, y_next, res_reg, res_next;
    logic [pcsm_pkg::ERR_W-1:0] err_reg, err_next;
    logic                       m_valid_reg, m_valid_next;
    logic [63:0]                m_data_reg, m_data_next;

    logic                       div_start;
    logic                       div_done;
    logic [WORD_BITS-1:0]       div_q;

    pcsm_div #(.WORD_BITS(WORD_BITS)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (x_reg),
        .divisor  (y_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // range helpers; the pointer, operand and read-word copies are in CW bits
    logic [CW-1:0] tp_c, bp_c, link_c, arg_c, rd_c;
    logic          rd_ok;
    logic [4:0]    lev_in;
    logic [3:0]    sub;
    logic [XW-1:0] top_ext;

    assign tp_c   = CW'(tp_reg);
    assign bp_c   = CW'(bp_reg);
    assign link_c = CW'(link_reg);
    assign arg_c  = CW'(arg_reg);
    assign rd_c   = CW'(mem_rdata_reg);
    // a word read as a link is usable when non-negative and below the depth
    assign rd_ok  = !mem_rdata_reg[WORD_BITS-1] && (rd_c < DEPTH_C);
    assign lev_in = 5'(s_tdata[5:4]);
    assign sub    = arg_reg[3:0];
    assign top_ext = XW'($signed(mem_rdata_reg));

    always_comb begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        pc_next      = pc_reg;
        bp_next      = bp_reg;
        tp_next      = tp_reg;
        link_next    = link_reg;
        op_next      = op_reg;
        cnt_next     = cnt_reg;
        arg_next     = arg_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        res_next     = res_reg;
        err_next     = err_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        mem_addr     = tp_reg;
        mem_wdata    = '0;
        div_start    = 1'b0;

        unique case (state_reg)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_addr  = clr_reg;
                clr_next  = clr_reg + 1'b1;
                if (CW'(clr_reg) == DEPTH_C - 1'b1) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    op_next  = s_tdata[3:0];
                    arg_next = s_tdata[16:6];
                    cnt_next = (lev_in > 5'(MAX_LEVEL)) ? LW'(MAX_LEVEL) : LW'(s_tdata[5:4]);
                    pc_next  = pc_reg + 1'b1;
                    err_next = pcsm_pkg::ERR_OK;
                    link_next = bp_reg;
                    state_next = S_DEC;
                end
            end
            S_DEC: begin
                state_next = S_TOP;
                unique case (op_reg)
                    pcsm_pkg::OP_LIT: begin
                        if (tp_c + 1'b1 < DEPTH_C) begin
                            mem_we    = 1'b1;
                            mem_addr  = PW'(tp_c + 1'b1);
                            mem_wdata = WORD_BITS'(arg_c);
                            tp_next   = PW'(tp_c + 1'b1);
                        end else begin
                            err_next = pcsm_pkg::ERR_RANGE;
                        end
                    end
                    pcsm_pkg::OP_OPR: begin
                        if (arg_reg > 11'(pcsm_pkg::SUB_GE)) begin
                            err_next = pcsm_pkg::ERR_BADOP;
                        end else if (sub == pcsm_pkg::SUB_RET) begin
                            if (bp_reg != '0 && bp_c + 2'd2 < DEPTH_C) begin
                                mem_re     = 1'b1;
                                mem_addr   = PW'(bp_c + 1'b1);
                                state_next = S_RET1;
                            end else begin
                                err_next = pcsm_pkg::ERR_RANGE;
                            end
                        end else if (sub == pcsm_pkg::SUB_NEG || sub == pcsm_pkg::SUB_ODD) begin
                            mem_re     = 1'b1;
                            state_next = S_UNARY;
                        end else if (tp_reg != '0) begin
                            mem_re     = 1'b1;
                            state_next = S_BIN1;
                        end else begin
                            err_next = pcsm_pkg::ERR_RANGE;
                        end
                    end
                    pcsm_pkg::OP_LOD, pcsm_pkg::OP_STO, pcsm_pkg::OP_CAL: begin
                        state_next = S_WALK;
                    end
                    pcsm_pkg::OP_INT: begin
                        if (tp_c + arg_c < DEPTH_C) begin
                            tp_next = PW'(tp_c + arg_c);
                        end else begin
                            err_next = pcsm_pkg::ERR_RANGE;
                        end
                    end
                    pcsm_pkg::OP_JMP: pc_next = arg_reg;
                    pcsm_pkg::OP_JPC: begin
                        if (tp_reg != '0) begin
                            mem_re     = 1'b1;
                            state_next = S_JPC2;
                        end else begin
                            err_next = pcsm_pkg::ERR_RANGE;
                        end
                    end
                    pcsm_pkg::OP_END: pc_next = '0;
                    default: err_next = pcsm_pkg::ERR_BADOP;
                endcase
            end
            S_UNARY: begin
                mem_we     = 1'b1;
                mem_wdata  = (sub == pcsm_pkg::SUB_NEG) ? (~mem_rdata_reg + 1'b1)
                                                        : {{(WORD_BITS-1){1'b0}}, mem_rdata_reg[0]};
                state_next = S_TOP;
            end
            S_BIN1: begin
                y_next     = mem_rdata_reg;
                mem_re     = 1'b1;
                mem_addr   = tp_reg - 1'b1;
                state_next = S_BIN2;
            end
            S_BIN2: begin
                x_next     = mem_rdata_reg;
                state_next = S_EXEC;
            end
            S_EXEC: begin
                state_next = S_WB;
                unique case (sub)
                    pcsm_pkg::SUB_ADD: res_next = x_reg + y_reg;
                    pcsm_pkg::SUB_SUB: res_next = x_reg - y_reg;
                    pcsm_pkg::SUB_MUL: res_next = WORD_BITS'(x_reg * y_reg);
                    pcsm_pkg::SUB_DIV: begin
                        if (y_reg == '0) begin
                            res_next = '0;
                            err_next = pcsm_pkg::ERR_DIV0;
                        end else begin
                            div_start  = 1'b1;
                            state_next = S_DIV;
                        end
                    end
                    pcsm_pkg::SUB_EQ: res_next = WORD_BITS'(x_reg == y_reg);
                    pcsm_pkg::SUB_NE: res_next = WORD_BITS'(x_reg != y_reg);
                    pcsm_pkg::SUB_LT: res_next = WORD_BITS'($signed(x_reg) < $signed(y_reg));
                    pcsm_pkg::SUB_LE: res_next = WORD_BITS'($signed(x_reg) <= $signed(y_reg));
                    pcsm_pkg::SUB_GT: res_next = WORD_BITS'($signed(x_reg) > $signed(y_reg));
                    default:          res_next = WORD_BITS'($signed(x_reg) >= $signed(y_reg));
                endcase
            end
            S_DIV: begin
                if (div_done) begin
                    res_next   = div_q;
                    state_next = S_WB;
                end
            end
            S_WB: begin
                mem_we     = 1'b1;
                mem_addr   = tp_reg - 1'b1;
                mem_wdata  = res_reg;
                tp_next    = tp_reg - 1'b1;
                state_next = S_TOP;
            end
            S_WALK: begin
                if (cnt_reg == '0) begin
                    state_next = S_ADDR;
                end else begin
                    mem_re     = 1'b1;
                    mem_addr   = link_reg;
                    state_next = S_WALK2;
                end
            end
            S_WALK2: begin
                if (rd_ok) begin
                    link_next  = PW'(rd_c);
                    cnt_next   = cnt_reg - 1'b1;
                    state_next = S_WALK;
                end else begin
                    err_next   = pcsm_pkg::ERR_RANGE;
                    state_next = S_TOP;
                end
            end
            S_ADDR: begin
                state_next = S_TOP;
                if (op_reg == pcsm_pkg::OP_LOD) begin
                    if (link_c + arg_c < DEPTH_C && tp_c + 1'b1 < DEPTH_C) begin
                        mem_re     = 1'b1;
                        mem_addr   = PW'(link_c + arg_c);
                        state_next = S_LOD2;
                    end else begin
                        err_next = pcsm_pkg::ERR_RANGE;
                    end
                end else if (op_reg == pcsm_pkg::OP_STO) begin
                    if (link_c + arg_c < DEPTH_C && tp_reg != '0) begin
                        mem_re     = 1'b1;
                        state_next = S_STO2;
                    end else begin
                        err_next = pcsm_pkg::ERR_RANGE;
                    end
                end else begin
                    if (tp_c + 2'd3 < DEPTH_C) begin
                        mem_we     = 1'b1;
                        mem_addr   = PW'(tp_c + 1'b1);
                        mem_wdata  = WORD_BITS'(link_c);
                        state_next = S_CAL2;
                    end else begin
                        err_next = pcsm_pkg::ERR_RANGE;
                    end
                end
            end
            S_LOD2: begin
                mem_we     = 1'b1;
                mem_addr   = PW'(tp_c + 1'b1);
                mem_wdata  = mem_rdata_reg;
                tp_next    = PW'(tp_c + 1'b1);
                state_next = S_TOP;
            end
            S_STO2: begin
                mem_we     = 1'b1;
                mem_addr   = PW'(link_c + arg_c);
                mem_wdata  = mem_rdata_reg;
                tp_next    = tp_reg - 1'b1;
                state_next = S_TOP;
            end
            S_CAL2: begin
                mem_we     = 1'b1;
                mem_addr   = PW'(tp_c + 2'd2);
                mem_wdata  = WORD_BITS'(bp_c);
                state_next = S_CAL3;
            end
            S_CAL3: begin
                mem_we     = 1'b1;
                mem_addr   = PW'(tp_c + 2'd3);
                mem_wdata  = WORD_BITS'(CW'(pc_reg));
                bp_next    = PW'(tp_c + 1'b1);
                pc_next    = arg_reg;
                state_next = S_TOP;
            end
            S_RET1: begin
                x_next     = mem_rdata_reg;    // saved base
                mem_re     = 1'b1;
                mem_addr   = PW'(bp_c + 2'd2);
                state_next = S_RET2;
            end
            S_RET2: begin
                if (!x_reg[WORD_BITS-1] && CW'(x_reg) < DEPTH_C) begin
                    tp_next = bp_reg - 1'b1;
                    pc_next = mem_rdata_reg[pcsm_pkg::ADDR_W-1:0];
                    bp_next = PW'(CW'(x_reg));
                end else begin
                    err_next = pcsm_pkg::ERR_RANGE;
                end
                state_next = S_TOP;
            end
            S_JPC2: begin
                if (mem_rdata_reg == '0) begin
                    pc_next = arg_reg;
                end
                tp_next    = tp_reg - 1'b1;
                state_next = S_TOP;
            end
            S_TOP: begin
                mem_re     = 1'b1;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {err_reg, (pc_reg == '0),
                                    pcsm_pkg::IDX_W'(CW'(bp_reg)),
                                    pcsm_pkg::IDX_W'(CW'(tp_reg)),
                                    top_ext[pcsm_pkg::OUT_W-1:0], pc_reg};
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            pc_reg      <= '0;
            bp_reg      <= PW'(1);
            tp_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            pc_reg      <= pc_next;
            bp_reg      <= bp_next;
            tp_reg      <= tp_next;
            m_valid_reg <= m_valid_next;
        end
        link_reg   <= link_next;
        op_reg     <= op_next;
        cnt_reg    <= cnt_next;
        arg_reg    <= arg_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        res_reg    <= res_next;
        err_reg    <= err_next;
        m_data_reg <= m_data_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule
